@@ rtl/pwfc_pkg.sv @@
package pwfc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] ModeV210Unpack = 3'd0;
  localparam logic [2:0] ModeR10k       = 3'd1;
  localparam logic [2:0] ModeRgbaShuf   = 3'd2;
  localparam logic [2:0] ModeToV210     = 3'd3;
  localparam logic [2:0] ModeDpx10      = 3'd4;

  localparam logic [1:0] RegFormatMode = 2'd0;
  localparam logic [1:0] RegRedShift   = 2'd1;
  localparam logic [1:0] RegGreenShift = 2'd2;
  localparam logic [1:0] RegBlueShift  = 2'd3;

  localparam logic [4:0] RedShiftReset   = 5'd0;
  localparam logic [4:0] GreenShiftReset = 5'd8;
  localparam logic [4:0] BlueShiftReset  = 5'd16;

  localparam logic [31:0] V210LowMask = 32'h0030_0c03;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GEAR = 2'd1,
    KIND_RGB  = 2'd2,
    KIND_PASS = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        eol;
    logic [31:0] data;
  } entry_t;

  typedef struct packed {
    logic [4:0] red_shift;
    logic [4:0] green_shift;
    logic [4:0] blue_shift;
  } shifts_t;

endpackage

@@ rtl/pwfc_front.sv @@
module pwfc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data,
  input  logic [31:0]           in_word,
  input  logic                  end_of_line,
  output pwfc_pkg::entry_t      entry,
  output pwfc_pkg::shifts_t     shifts
);

  logic [2:0] format_mode;
  logic [4:0] red_shift;
  logic [4:0] green_shift;
  logic [4:0] blue_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= pwfc_pkg::ModeV210Unpack;
      red_shift   <= pwfc_pkg::RedShiftReset;
      green_shift <= pwfc_pkg::GreenShiftReset;
      blue_shift  <= pwfc_pkg::BlueShiftReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwfc_pkg::RegFormatMode: format_mode <= cfg_data[2:0];
        pwfc_pkg::RegRedShift:   red_shift   <= cfg_data;
        pwfc_pkg::RegGreenShift: green_shift <= cfg_data;
        pwfc_pkg::RegBlueShift:  blue_shift  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign shifts = '{red_shift: red_shift, green_shift: green_shift,
                    blue_shift: blue_shift};

  logic        default_shifts;
  logic [31:0] widened;

  assign default_shifts = (red_shift == pwfc_pkg::RedShiftReset) &&
                          (green_shift == pwfc_pkg::GreenShiftReset) &&
                          (blue_shift == pwfc_pkg::BlueShiftReset);

  assign widened = ({8'd0, in_word[31:24], in_word[31:24], in_word[31:24]} &
                    pwfc_pkg::V210LowMask) |
                   {22'd0, in_word[7:0], 2'd0} |
                   {12'd0, in_word[15:8], 12'd0} |
                   {2'd0, in_word[23:16], 22'd0};

  always_comb begin
    entry.eol  = end_of_line;
    entry.kind = pwfc_pkg::KIND_NONE;
    entry.data = in_word;
    unique case (format_mode)
      pwfc_pkg::ModeV210Unpack: begin
        entry.kind = pwfc_pkg::KIND_GEAR;
        entry.data = {8'd0, in_word[29:22], in_word[19:12], in_word[9:2]};
      end
      pwfc_pkg::ModeR10k: begin
        entry.kind = pwfc_pkg::KIND_RGB;
        entry.data = {8'd0, in_word[19:16], in_word[31:28],
                      in_word[13:8], in_word[23:22], in_word[7:0]};
      end
      pwfc_pkg::ModeRgbaShuf: begin
        if (default_shifts) begin
          entry.kind = pwfc_pkg::KIND_PASS;
        end else begin
          entry.kind = pwfc_pkg::KIND_RGB;
          entry.data = {8'd0, in_word[23:0]};
        end
      end
      pwfc_pkg::ModeToV210: begin
        entry.kind = pwfc_pkg::KIND_PASS;
        entry.data = widened;
      end
      pwfc_pkg::ModeDpx10: begin
        entry.kind = pwfc_pkg::KIND_RGB;
        entry.data = {8'd0, in_word[11:4], in_word[21:14], in_word[31:24]};
      end
      default: entry.kind = pwfc_pkg::KIND_NONE;
    endcase
  end

endmodule

@@ rtl/pwfc_queue.sv @@
module pwfc_queue #(
  parameter int unsigned DEPTH = pwfc_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pwfc_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output pwfc_pkg::entry_t  head_entry
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  pwfc_pkg::entry_t slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/pwfc_back.sv @@
module pwfc_back (
  input  logic               clk,
  input  logic               rst,
  input  pwfc_pkg::shifts_t  shifts,
  input  logic               head_valid,
  input  pwfc_pkg::entry_t   head_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_word
);

  logic [23:0] held_bytes;
  logic [1:0]  held_count;
  logic [23:0] held_bytes_next;
  logic [1:0]  held_count_next;
  logic [55:0] gear_all;
  logic [31:0] placed;
  logic [31:0] result;
  logic        produces;
  logic        slot_free;

  assign gear_all = {32'd0, held_bytes} |
                    ({24'd0, head_entry.data} << {held_count, 3'd0});

  assign placed = ({24'd0, head_entry.data[7:0]}   << shifts.red_shift) |
                  ({24'd0, head_entry.data[15:8]}  << shifts.green_shift) |
                  ({24'd0, head_entry.data[23:16]} << shifts.blue_shift);

  always_comb begin
    produces        = 1'b0;
    result          = head_entry.data;
    held_bytes_next = held_bytes;
    held_count_next = held_count;
    unique case (head_entry.kind)
      pwfc_pkg::KIND_GEAR: begin
        if (held_count == 2'd0) begin
          held_bytes_next = head_entry.data[23:0];
          held_count_next = 2'd3;
        end else begin
          produces        = 1'b1;
          result          = gear_all[31:0];
          held_bytes_next = gear_all[55:32];
          held_count_next = held_count - 2'd1;
        end
      end
      pwfc_pkg::KIND_RGB: begin
        produces = 1'b1;
        result   = placed;
      end
      pwfc_pkg::KIND_PASS: produces = 1'b1;
      default: produces = 1'b0;
    endcase
    if (head_entry.eol) begin
      held_bytes_next = '0;
      held_count_next = '0;
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign pop       = head_valid && (!produces || slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        held_bytes <= held_bytes_next;
        held_count <= held_count_next;
      end
      if (pop && produces) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produces) begin
      out_word <= result;
    end
  end

endmodule

@@ rtl/pixel_word_format_converter_top.sv @@
// channel  | handshake            | payload
// ---------+----------------------+-------------------------
// in       | in_valid / in_stall  | in_word, end_of_line
// out      | out_valid / out_stall| out_word
// cfg      | cfg_we               | cfg_index, cfg_data
//
// One word accepted per cycle while in_stall is low; the queue slot is written at
// acceptance and the output register when the back end pops a word-producing
// entry, so every word passes through the queue before the output register.
// in_stall rises only when the queue is full; the back end drains the queue
// one word per cycle while the output register is free or being taken.
// Reset clears config to mode 0 with shifts 0/8/16, empties the gearbox and queue.
module pixel_word_format_converter_top #(
  parameter int unsigned QUEUE_DEPTH = pwfc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_word,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word
);

  pwfc_pkg::entry_t  front_entry;
  pwfc_pkg::entry_t  head_entry;
  pwfc_pkg::shifts_t shifts;
  logic              queue_full;
  logic              head_valid;
  logic              pop;

  assign in_stall = queue_full;

  pwfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_word     (in_word),
    .end_of_line (end_of_line),
    .entry       (front_entry),
    .shifts      (shifts)
  );

  pwfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !queue_full),
    .push_entry (front_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  pwfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .shifts     (shifts),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule
